/* hdl/fbp_pkg.sv */
// Shared types, constants and helpers for the frame buffer with ID priority.
`timescale 1ns / 1ps
`default_nettype none

package fbp_pkg;

  localparam int DEPTH       = 16;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int ID_W        = 11;
  localparam int LEN_W       = 9;
  localparam int ACT_W       = 3;
  localparam int STATUS_W    = 2;
  localparam int LEN_MAX     = (1 << LEN_W) - 1;
  localparam int BYTES_W     = $clog2(DEPTH * LEN_MAX + 1);
  localparam int COUNT_OUT_W = 5;
  localparam int BYTES_OUT_W = 13;
  localparam int COUNT_SAT   = (1 << COUNT_OUT_W) - 1;
  localparam int BYTES_SAT   = (1 << BYTES_OUT_W) - 1;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUT    = 3'd0,
    ACT_BY_ID  = 3'd1,
    ACT_DELETE = 3'd2,
    ACT_LOWEST = 3'd3,
    ACT_OLDEST = 3'd4
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FINAL
  } state_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [ID_W-1:0]  in_frame_id;
    logic [LEN_W-1:0] in_byte_length;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic                   delivered;
    logic [ID_W-1:0]        out_frame_id;
    logic [LEN_W-1:0]       out_byte_length;
    logic [COUNT_OUT_W-1:0] queue_count;
    logic [BYTES_OUT_W-1:0] queue_bytes;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic lowest_req;
    logic scan_end;
    logic slot_free;
  } dp_stat_t;

  function automatic logic [COUNT_OUT_W-1:0] sat_count(input logic [CNT_W-1:0] c);
    logic [COUNT_OUT_W-1:0] r;
    if (int'(c) > COUNT_SAT) r = COUNT_OUT_W'(COUNT_SAT);
    else r = COUNT_OUT_W'(c);
    return r;
  endfunction

  function automatic logic [BYTES_OUT_W-1:0] sat_bytes(input logic [BYTES_W-1:0] b);
    logic [BYTES_OUT_W-1:0] r;
    if (int'(b) > BYTES_SAT) r = BYTES_OUT_W'(BYTES_SAT);
    else r = BYTES_OUT_W'(b);
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/fbp_in_if.sv */
// Request channel: valid/ready handshake carrying one action transaction.
`timescale 1ns / 1ps
`default_nettype none

interface fbp_in_if;
  logic             valid;
  logic             ready;
  fbp_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hdl/fbp_out_if.sv */
// Response channel: valid/ready handshake carrying one result transaction.
`timescale 1ns / 1ps
`default_nettype none

interface fbp_out_if;
  logic               valid;
  logic               ready;
  fbp_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hdl/fbp_datapath.sv */
// Datapath: descriptor entries, totals, ID match, minimum scan and result register.
`timescale 1ns / 1ps
`default_nettype none

module fbp_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire fbp_pkg::in_item_t   in_item,
  input  wire fbp_pkg::ctrl_cmd_t  cmd,
  output fbp_pkg::dp_stat_t        stat,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output fbp_pkg::out_item_t       out_item
);

  fbp_pkg::in_item_t                 cur;
  logic [fbp_pkg::ID_W-1:0]          id_mem  [fbp_pkg::DEPTH];
  logic [fbp_pkg::LEN_W-1:0]         len_mem [fbp_pkg::DEPTH];
  logic [fbp_pkg::CNT_W-1:0]         count;
  logic [fbp_pkg::BYTES_W-1:0]       bytes;
  logic [fbp_pkg::CNT_W-1:0]         idx;
  logic [fbp_pkg::ID_W-1:0]          best_id;
  logic [fbp_pkg::LEN_W-1:0]         best_len;

  logic                              hit_any;
  logic [fbp_pkg::IDX_W-1:0]         hit_pos;
  logic [fbp_pkg::LEN_W-1:0]         hit_len;
  logic [fbp_pkg::IDX_W-1:0]         idx_sel;
  logic [fbp_pkg::ID_W-1:0]          scan_id;
  logic [fbp_pkg::LEN_W-1:0]         scan_len;
  logic                              full;
  logic                              empty;

  fbp_pkg::status_t                  res_status;
  logic                              res_dlv;
  logic [fbp_pkg::ID_W-1:0]          res_id;
  logic [fbp_pkg::LEN_W-1:0]         res_len;
  logic [fbp_pkg::CNT_W-1:0]         count_next;
  logic [fbp_pkg::BYTES_W-1:0]       bytes_next;
  logic                              do_put;
  logic                              do_remove;

  assign full  = (count == fbp_pkg::CNT_W'(fbp_pkg::DEPTH));
  assign empty = (count == '0);

  // First (oldest) occupied entry whose ID matches.
  always_comb begin
    hit_any = 1'b0;
    hit_pos = '0;
    for (int i = fbp_pkg::DEPTH - 1; i >= 0; i--) begin
      if ((fbp_pkg::CNT_W'(i) < count) && (id_mem[i] == cur.in_frame_id)) begin
        hit_any = 1'b1;
        hit_pos = fbp_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    hit_len = '0;
    for (int i = 0; i < fbp_pkg::DEPTH; i++) begin
      if (fbp_pkg::IDX_W'(i) == hit_pos) hit_len = hit_len | len_mem[i];
    end
  end

  assign idx_sel  = idx[fbp_pkg::IDX_W-1:0];
  assign scan_id  = id_mem[idx_sel];
  assign scan_len = len_mem[idx_sel];

  always_comb begin
    res_status = fbp_pkg::ST_OK;
    res_dlv    = 1'b0;
    res_id     = '0;
    res_len    = '0;
    count_next = count;
    bytes_next = bytes;
    do_put     = 1'b0;
    do_remove  = 1'b0;
    unique case (fbp_pkg::action_t'(cur.action))
      fbp_pkg::ACT_PUT: begin
        if (full) begin
          res_status = fbp_pkg::ST_FULL;
        end else begin
          do_put     = 1'b1;
          count_next = count + fbp_pkg::CNT_W'(1);
          bytes_next = bytes + fbp_pkg::BYTES_W'(cur.in_byte_length);
        end
      end
      fbp_pkg::ACT_BY_ID, fbp_pkg::ACT_DELETE: begin
        if (!hit_any) begin
          res_status = fbp_pkg::ST_MISS;
        end else begin
          do_remove  = 1'b1;
          count_next = count - fbp_pkg::CNT_W'(1);
          bytes_next = bytes - fbp_pkg::BYTES_W'(hit_len);
          if (fbp_pkg::action_t'(cur.action) == fbp_pkg::ACT_BY_ID) begin
            res_dlv = 1'b1;
            res_id  = cur.in_frame_id;
            res_len = hit_len;
          end
        end
      end
      fbp_pkg::ACT_LOWEST: begin
        if (empty) begin
          res_status = fbp_pkg::ST_MISS;
        end else begin
          res_dlv = 1'b1;
          res_id  = best_id;
          res_len = best_len;
        end
      end
      fbp_pkg::ACT_OLDEST: begin
        if (empty) begin
          res_status = fbp_pkg::ST_MISS;
        end else begin
          res_dlv = 1'b1;
          res_id  = id_mem[0];
          res_len = len_mem[0];
        end
      end
      default: begin
      end
    endcase
  end

  assign stat.lowest_req = (fbp_pkg::action_t'(cur.action) == fbp_pkg::ACT_LOWEST) && !empty;
  assign stat.scan_end   = (idx >= count);
  assign stat.slot_free  = !out_valid || out_ready;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      bytes     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        count     <= count_next;
        bytes     <= bytes_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload and entry storage
  always_ff @(posedge clk) begin
    if (cmd.load) cur <= in_item;

    if (cmd.scan_start) begin
      idx      <= fbp_pkg::CNT_W'(1);
      best_id  <= id_mem[0];
      best_len <= len_mem[0];
    end else if (cmd.scan_step) begin
      if (scan_id < best_id) begin
        best_id  <= scan_id;
        best_len <= scan_len;
      end
      idx <= idx + fbp_pkg::CNT_W'(1);
    end

    if (cmd.commit && do_put) begin
      id_mem[count[fbp_pkg::IDX_W-1:0]]  <= cur.in_frame_id;
      len_mem[count[fbp_pkg::IDX_W-1:0]] <= cur.in_byte_length;
    end

    if (cmd.commit && do_remove) begin
      for (int i = 0; i < fbp_pkg::DEPTH - 1; i++) begin
        if (fbp_pkg::IDX_W'(i) >= hit_pos) begin
          id_mem[i]  <= id_mem[i+1];
          len_mem[i] <= len_mem[i+1];
        end
      end
    end

    if (cmd.commit) begin
      out_item.status          <= res_status;
      out_item.delivered       <= res_dlv;
      out_item.out_frame_id    <= res_id;
      out_item.out_byte_length <= res_len;
      out_item.queue_count     <= fbp_pkg::sat_count(count_next);
      out_item.queue_bytes     <= fbp_pkg::sat_bytes(bytes_next);
    end
  end

endmodule

`default_nettype wire

/* hdl/fbp_ctrl.sv */
// Controller: sequences accept, minimum scan and commit for one transaction at a time.
`timescale 1ns / 1ps
`default_nettype none

module fbp_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output fbp_pkg::ctrl_cmd_t      cmd,
  input  wire fbp_pkg::dp_stat_t  stat
);

  fbp_pkg::state_t state;
  fbp_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= fbp_pkg::S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      fbp_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = fbp_pkg::S_EXEC;
        end
      end
      fbp_pkg::S_EXEC: begin
        if (stat.lowest_req) begin
          cmd.scan_start = 1'b1;
          state_next     = fbp_pkg::S_SCAN;
        end else if (stat.slot_free) begin
          cmd.commit = 1'b1;
          state_next = fbp_pkg::S_IDLE;
        end
      end
      fbp_pkg::S_SCAN: begin
        if (stat.scan_end) state_next = fbp_pkg::S_FINAL;
        else cmd.scan_step = 1'b1;
      end
      fbp_pkg::S_FINAL: begin
        if (stat.slot_free) begin
          cmd.commit = 1'b1;
          state_next = fbp_pkg::S_IDLE;
        end
      end
      default: state_next = fbp_pkg::S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/frame_buffer_id_priority.sv */
// Top level: frame descriptor buffer with ID lookup and lowest-ID delivery.
//
//   channel  modport  payload       transaction
//   req      sink     in_item_t     one action (put, by id, delete, lowest, oldest)
//   rsp      source   out_item_t    one result per action
//
// Put, by-id, delete, oldest, unused codes and deliver-lowest on an empty buffer
// are captured in S_IDLE, then matched and committed in S_EXEC; deliver-lowest
// otherwise passes S_IDLE, S_EXEC, S_SCAN and S_FINAL, where one comparator walks
// the stored IDs one per cycle.
// The result sits in an output register; the next request is taken while it waits.
// rst is synchronous: it empties the buffer and drops rsp.valid.
// A stalled rsp blocks only the commit of the following transaction.
`timescale 1ns / 1ps
`default_nettype none

module frame_buffer_id_priority (
  input  wire logic   clk,
  input  wire logic   rst,
  fbp_in_if.sink      req,
  fbp_out_if.source   rsp
);

  fbp_pkg::ctrl_cmd_t cmd;
  fbp_pkg::dp_stat_t  stat;
  logic               in_ready;

  assign req.ready = in_ready;

  fbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  fbp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (req.data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_item  (rsp.data)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted while a transaction is in flight");

  a_commit_gives_result: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> rsp.valid)
    else $error("commit did not produce a result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!rsp.valid || rsp.ready))
    else $error("result overwritten before it was taken");

  a_scan_bounded: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |-> !stat.scan_end)
    else $error("scan stepped past the stored entries");

  a_delivered_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.delivered |-> rsp.data.status == fbp_pkg::ST_OK)
    else $error("delivery reported with an error status");

endmodule

`default_nettype wire
